// ===== rtl/core/hrls_pkg.sv =====
// Shared types and constants for the horizontal run-length smoothing block.
package hrls_pkg;

   localparam int PIX_W = 8;
   localparam int GAP_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAP_W-1:0] GAP_LIMIT = 6'd63;
   localparam logic [PIX_W-1:0] FILL_WHITE = 8'd255;
   localparam logic [PIX_W-1:0] FILL_BLACK = 8'd0;

   localparam logic [CSR_ADDR_W-3:0] CSR_MAX_GAP = 1'd0;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   typedef struct packed {
      logic accept;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic hold;
      logic fill_left;
   } status_type;

endpackage

// ===== rtl/core/hrls_req_if.sv =====
// Input channel carrying one pixel word and its row flag.
interface hrls_req_if;
   logic                      valid;
   logic                      ready;
   logic [hrls_pkg::PIX_W-1:0] pixel_in;
   logic                      row_last;

   modport source (output valid, output pixel_in, output row_last, input ready);
   modport sink (input valid, input pixel_in, input row_last, output ready);
endinterface

// ===== rtl/core/hrls_rsp_if.sv =====
// Result channel carrying one output pixel word and its flags.
interface hrls_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hrls_pkg::PIX_W-1:0] pixel_out;
   logic                      row_end;
   logic                      run_last;

   modport source (output valid, output pixel_out, output row_end, output run_last,
                   input ready);
   modport sink (input valid, input pixel_out, input row_end, input run_last,
                 output ready);
endinterface

// ===== rtl/core/hrls_ctrl.sv =====
// Controller state machine that sequences input acceptance and burst output.
module hrls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hrls_pkg::cmd_type    cmd,
   input  hrls_pkg::status_type status
);

   hrls_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   logic                slot_free;

   assign req_ready = (state_ff == hrls_pkg::ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      cmd.accept = req_valid && req_ready;
      cmd.emit   = (state_ff == hrls_pkg::ST_BURST) && slot_free;
      state_in   = state_ff;
      unique case (state_ff)
         hrls_pkg::ST_IDLE: begin
            if (cmd.accept && !status.hold) begin
               state_in = hrls_pkg::ST_BURST;
            end
         end
         hrls_pkg::ST_BURST: begin
            if (cmd.emit && !status.fill_left) begin
               state_in = hrls_pkg::ST_IDLE;
            end
         end
         default: state_in = hrls_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hrls_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/core/hrls_dp.sv =====
// Datapath holding the gap state, the burst counter and the output word register.
module hrls_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  hrls_pkg::cmd_type           cmd,
   output hrls_pkg::status_type        status,
   input  logic [hrls_pkg::GAP_W-1:0]  max_gap,
   input  logic [hrls_pkg::PIX_W-1:0]  pixel_in,
   input  logic                        row_last,
   output logic [hrls_pkg::PIX_W-1:0]  pixel_out,
   output logic                        row_end,
   output logic                        run_last
);

   logic [hrls_pkg::GAP_W-1:0] pend_ff, pend_in;
   logic                       obj_ff, obj_in;
   logic [hrls_pkg::GAP_W-1:0] cnt_ff, cnt_in;
   logic [hrls_pkg::PIX_W-1:0] fill_ff, fill_in;
   logic [hrls_pkg::PIX_W-1:0] pix_ff, pix_in;
   logic                       last_ff, last_in;
   logic [hrls_pkg::PIX_W-1:0] out_pix_ff, out_pix_in;
   logic                       out_end_ff, out_end_in;
   logic                       out_last_ff, out_last_in;
   logic [hrls_pkg::GAP_W-1:0] limit;
   logic                       hold;

   assign limit = (max_gap < hrls_pkg::GAP_LIMIT) ? max_gap : hrls_pkg::GAP_LIMIT;
   assign hold  = (pixel_in == hrls_pkg::FILL_BLACK) && obj_ff && !row_last &&
                  (pend_ff < limit);

   assign status.hold      = hold;
   assign status.fill_left = (cnt_ff != '0);

   always_comb begin
      pend_in = pend_ff;
      obj_in  = obj_ff;
      cnt_in  = cnt_ff;
      fill_in = fill_ff;
      pix_in  = pix_ff;
      last_in = last_ff;
      if (cmd.accept) begin
         pix_in  = pixel_in;
         last_in = row_last;
         pend_in = '0;
         cnt_in  = '0;
         fill_in = hrls_pkg::FILL_BLACK;
         if (pixel_in != hrls_pkg::FILL_BLACK) begin
            cnt_in  = pend_ff;
            fill_in = hrls_pkg::FILL_WHITE;
            obj_in  = 1'b1;
         end else if (!obj_ff) begin
            cnt_in = '0;
         end else if (!hold) begin
            cnt_in = pend_ff;
            obj_in = 1'b0;
         end else begin
            pend_in = pend_ff + 1'b1;
         end
         if (row_last) begin
            pend_in = '0;
            obj_in  = 1'b0;
         end
      end else if (cmd.emit && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      out_pix_in  = out_pix_ff;
      out_end_in  = out_end_ff;
      out_last_in = out_last_ff;
      if (cmd.emit) begin
         if (cnt_ff != '0) begin
            out_pix_in  = fill_ff;
            out_end_in  = 1'b0;
            out_last_in = 1'b0;
         end else begin
            out_pix_in  = pix_ff;
            out_end_in  = last_ff;
            out_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         obj_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         obj_ff  <= obj_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff     <= fill_in;
      pix_ff      <= pix_in;
      last_ff     <= last_in;
      out_pix_ff  <= out_pix_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
   end

   assign pixel_out = out_pix_ff;
   assign row_end   = out_end_ff;
   assign run_last  = out_last_ff;

endmodule

// ===== rtl/core/horizontal_run_length_smoothing.sv =====
// Top level of the horizontal run-length smoothing block with its register port.
// A held zero is only accepted; any other pixel is accepted and then emits one result
// word per cycle (held gap words plus the pixel itself) when rsp is not stalled.
// The burst counter drains held gap words one per cycle while rsp is not stalled.
// Result words appear from the output register, which captures each word as it is produced.
// Synchronous active-high reset clears max_gap, the gap state and the output valid.
module horizontal_run_length_smoothing (
   input  logic                               clock,
   input  logic                               reset,
   hrls_req_if.sink                           req_if,
   hrls_rsp_if.source                         rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hrls_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hrls_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hrls_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   hrls_pkg::cmd_type          cmd;
   hrls_pkg::status_type       status;
   logic [hrls_pkg::GAP_W-1:0] max_gap_ff, max_gap_in;
   logic                       csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[hrls_pkg::CSR_ADDR_W-1:2] == hrls_pkg::CSR_MAX_GAP);

   always_comb begin
      max_gap_in = max_gap_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         max_gap_in = csr_pwdata[hrls_pkg::GAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff <= '0;
      end else begin
         max_gap_ff <= max_gap_in;
      end
   end

   assign csr_prdata = csr_hit ?
                       {{(hrls_pkg::CSR_DATA_W-hrls_pkg::GAP_W){1'b0}}, max_gap_ff} : '0;

   hrls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   hrls_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .max_gap   (max_gap_ff),
      .pixel_in  (req_if.pixel_in),
      .row_last  (req_if.row_last),
      .pixel_out (rsp_if.pixel_out),
      .row_end   (rsp_if.row_end),
      .run_last  (rsp_if.run_last)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.pixel_in != hrls_pkg::FILL_BLACK))
      |=> !req_if.ready)
      else $error("Nonzero pixel accepted without starting a burst.");

   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.row_last) |=> !req_if.ready)
      else $error("Row end accepted without starting a burst.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.row_end) |-> rsp_if.run_last)
      else $error("Row end word is not the last word of its burst.");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the horizontal run-length smoothing block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [hrls_pkg::PIX_W-1:0] pixel;
      logic                       row_end;
      logic                       run_last;
   } result_word_type;

   class smoothing_scoreboard;
      logic [hrls_pkg::GAP_W-1:0] max_gap;
      logic [hrls_pkg::GAP_W-1:0] held_zeros;
      logic                       object_open;
      result_word_type            pending_words[$];
      int                         errors;

      function new();
         max_gap = '0;
         held_zeros = '0;
         object_open = 1'b0;
         errors = 0;
      endfunction

      function void queue_burst(int count, logic [hrls_pkg::PIX_W-1:0] fill,
                                logic [hrls_pkg::PIX_W-1:0] pix, logic last_flag);
         result_word_type w;
         for (int i = 0; i < count; i++) begin
            w.pixel = fill;
            w.row_end = 1'b0;
            w.run_last = 1'b0;
            pending_words.push_back(w);
         end
         w.pixel = pix;
         w.row_end = last_flag;
         w.run_last = 1'b1;
         pending_words.push_back(w);
      endfunction

      function void note_word(logic [hrls_pkg::PIX_W-1:0] pix, logic last_flag);
         logic [hrls_pkg::GAP_W-1:0] limit;
         limit = (max_gap < hrls_pkg::GAP_LIMIT) ? max_gap : hrls_pkg::GAP_LIMIT;
         if (pix != hrls_pkg::FILL_BLACK) begin
            queue_burst(int'(held_zeros), hrls_pkg::FILL_WHITE, pix, last_flag);
            held_zeros = '0;
            object_open = 1'b1;
         end else if (!object_open) begin
            queue_burst(0, hrls_pkg::FILL_BLACK, hrls_pkg::FILL_BLACK, last_flag);
            held_zeros = '0;
         end else if (last_flag || held_zeros >= limit) begin
            queue_burst(int'(held_zeros), hrls_pkg::FILL_BLACK, hrls_pkg::FILL_BLACK,
                        last_flag);
            held_zeros = '0;
            object_open = 1'b0;
         end else begin
            held_zeros = held_zeros + 1'b1;
         end
         if (last_flag) begin
            held_zeros = '0;
            object_open = 1'b0;
         end
      endfunction

      function void check_word(result_word_type got);
         result_word_type want;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word pixel_out=%0d row_end=%0b run_last=%0b",
                     $time, got.pixel, got.row_end, got.run_last);
            return;
         end
         want = pending_words.pop_front();
         if (got.pixel != want.pixel) begin
            errors++;
            $display("%0t: pixel_out expected %0d, got %0d", $time, want.pixel, got.pixel);
         end
         if (got.row_end != want.row_end) begin
            errors++;
            $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, got.row_end);
         end
         if (got.run_last != want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b, got %0b", $time, want.run_last,
                     got.run_last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [hrls_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [hrls_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [hrls_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   bit idle_enable = 1'b1;
   bit hold_request = 1'b0;

   smoothing_scoreboard sb = new();

   hrls_req_if req_ch();
   hrls_rsp_if rsp_ch();

   horizontal_run_length_smoothing u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [hrls_pkg::PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 8'd1;
         1: return 8'd255;
         default: return hrls_pkg::PIX_W'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic write_max_gap(input logic [hrls_pkg::GAP_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {hrls_pkg::CSR_MAX_GAP, 2'b00};
      csr_pwdata <= hrls_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.max_gap = value;
   endtask

   task automatic send_word(input logic [hrls_pkg::PIX_W-1:0] pix, input logic last_flag);
      while (idle_enable && $urandom_range(0, 99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel_in <= pix;
      req_ch.row_last <= last_flag;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_word(pix, last_flag);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int budget);
      int                         sent;
      int                         objects;
      int                         gap;
      bit                         first_gap;
      logic [hrls_pkg::PIX_W-1:0] row_q[$];
      sent = 0;
      first_gap = 1'b1;
      while (sent < budget) begin
         row_q.delete();
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 8)) begin
               send_word($urandom_range(0, 1) ? random_pixel() : hrls_pkg::FILL_BLACK,
                         $urandom_range(0, 4) == 0);
               sent++;
            end
         end else begin
            repeat ($urandom_range(0, 3)) row_q.push_back(hrls_pkg::FILL_BLACK);
            objects = (sb.max_gap > 20) ? 2 : $urandom_range(1, 4);
            for (int k = 0; k < objects; k++) begin
               repeat ($urandom_range(1, 3)) row_q.push_back(random_pixel());
               if (k < objects - 1) begin
                  if (first_gap) begin
                     gap = sb.max_gap;
                     first_gap = 1'b0;
                  end else begin
                     case ($urandom_range(0, 3))
                        0: gap = sb.max_gap;
                        1: gap = sb.max_gap + 1;
                        2: gap = (sb.max_gap == 0) ? 0 : sb.max_gap - 1;
                        default: gap = $urandom_range(1, sb.max_gap + 2);
                     endcase
                  end
                  repeat (gap) row_q.push_back(hrls_pkg::FILL_BLACK);
               end
            end
            repeat ($urandom_range(0, 3)) row_q.push_back(hrls_pkg::FILL_BLACK);
            foreach (row_q[i]) begin
               send_word(row_q[i], i == row_q.size() - 1);
               sent++;
            end
         end
      end
   endtask

   initial begin : result_sink
      int              hold_left;
      result_word_type got;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.pixel = rsp_ch.pixel_out;
            got.row_end = rsp_ch.row_end;
            got.run_last = rsp_ch.run_last;
            sb.check_word(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_enable && $urandom_range(0, 99) < 9);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("** horizontal_run_length_smoothing: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [hrls_pkg::GAP_W-1:0] gap_settings[7];
      req_ch.valid = 1'b0;
      req_ch.pixel_in = '0;
      req_ch.row_last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gap_settings = '{6'd0, 6'd63, 6'd1, hrls_pkg::GAP_W'($urandom_range(2, 62)), 6'd5,
                       6'd63, hrls_pkg::GAP_W'($urandom_range(0, 63))};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Leading zeros, a filled gap, an overlong gap, a trailing run and short rows.
      write_max_gap(6'd3);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd255, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd1, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd128, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b1);
      send_word(8'd7, 1'b1);
      send_word(8'd0, 1'b1);
      send_word(8'd170, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd0, 1'b0);
      settle();
      send_word(8'd85, 1'b0);
      send_word(8'd0, 1'b0);
      send_word(8'd9, 1'b1);
      settle();

      foreach (gap_settings[p]) begin
         write_max_gap(gap_settings[p]);
         idle_enable = (p != 4);
         if (p == 5)
            hold_request = 1'b1;
         run_phase(20);
         settle();
      end
      repeat (10) @(posedge clock);

      if (sb.errors == 0 && sb.pending_words.size() == 0)
         $display("** horizontal_run_length_smoothing: PASSED **");
      else
         $display("** horizontal_run_length_smoothing: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/hrls_pkg.sv
rtl/core/hrls_req_if.sv
rtl/core/hrls_rsp_if.sv
rtl/core/hrls_ctrl.sv
rtl/core/hrls_dp.sv
rtl/core/horizontal_run_length_smoothing.sv
tb/testbench.sv
